// ===== hdl/fbm_pkg.sv =====
// Shared widths, register index codes and splits for the FDR/Bonferroni marker.
`default_nettype none

package fbm_pkg;

  // Field widths
  localparam int P_W    = 61;        // p-values and alphas, unsigned Q0.61
  localparam int CNT_W  = 48;        // test counts
  localparam int IDX_W  = 32;        // positions and cis ranks
  localparam int CUT_W  = IDX_W + 1; // cut positions and ranks
  localparam int SIG_W  = 5;
  localparam int CFG_IDX_W = 3;

  // Operand splits for the partial products
  localparam int PLO_W = 31;
  localparam int PHI_W = P_W - PLO_W;
  localparam int CLO_W = 24;
  localparam int CHI_W = CNT_W - CLO_W;

  // Partial product widths
  localparam int PPLL_W = PLO_W + CLO_W;
  localparam int PPLH_W = PLO_W + CHI_W;
  localparam int PPHL_W = PHI_W + CLO_W;
  localparam int PPHH_W = PHI_W + CHI_W;
  localparam int RFL_W  = CUT_W + PLO_W;
  localparam int RFH_W  = CUT_W + PHI_W;
  localparam int KFL_W  = IDX_W + PLO_W;
  localparam int KFH_W  = IDX_W + PHI_W;

  // Full product widths
  localparam int PN_W = P_W + CNT_W;
  localparam int RF_W = CUT_W + P_W;
  localparam int KF_W = IDX_W + P_W;

  // Significance mask bits
  localparam int SIG_TRANS_BONF = 0;
  localparam int SIG_TRANS_FDR  = 1;
  localparam int SIG_THRESHOLD  = 2;
  localparam int SIG_CIS_BONF   = 3;
  localparam int SIG_CIS_FDR    = 4;

  // Pass commands
  localparam logic CMD_SCAN = 1'b0;
  localparam logic CMD_MARK = 1'b1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_N_TOTAL     = 3'd0,
    CFG_N_CIS_TOTAL = 3'd1,
    CFG_CIS_MODE    = 3'd2,
    CFG_BONF_ALPHA  = 3'd3,
    CFG_FDR_LEVEL   = 3'd4,
    CFG_P_THRESHOLD = 3'd5
  } cfg_index_t;

endpackage

`default_nettype wire

// ===== hdl/fdr_bonferroni_marker.sv =====
// Benjamini-Hochberg and Bonferroni significance marker over sorted p-values.
// Throughput: one word per cycle; the four-stage pipe (input, partial products,
// summed products, result register) advances whenever the result register is free.
// Reset clears the configuration registers, pass state, counters, cuts and pipe
// valid bits; no word is taken while reset is high.
`default_nettype none

module fdr_bonferroni_marker (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // configuration channel
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [fbm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [fbm_pkg::P_W-1:0]     cfg_data,
  // input channel
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        command,
  input  wire logic [fbm_pkg::P_W-1:0]     p_value,
  input  wire logic                        is_cis,
  input  wire logic                        last_of_pass,
  // output channel
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [fbm_pkg::IDX_W-1:0]        rank_position,
  output logic [fbm_pkg::SIG_W-1:0]        significance,
  output logic                             last
);

  // Configuration registers
  logic [fbm_pkg::CNT_W-1:0] n_total;
  logic [fbm_pkg::CNT_W-1:0] n_cis_total;
  logic                      cis_mode;
  logic [fbm_pkg::P_W-1:0]   bonferroni_alpha;
  logic [fbm_pkg::P_W-1:0]   fdr_level;
  logic [fbm_pkg::P_W-1:0]   p_threshold;

  // Pass state
  logic [fbm_pkg::IDX_W-1:0] position_count;
  logic [fbm_pkg::IDX_W-1:0] cis_rank_count;
  logic [fbm_pkg::CUT_W-1:0] trans_fdr_cut;
  logic [fbm_pkg::CUT_W-1:0] cis_fdr_cut;
  logic                      in_mark_pass;

  // Stage 1: input register
  logic                      v1, cmd1, cis1, last1;
  logic [fbm_pkg::P_W-1:0]   p1;
  logic [fbm_pkg::IDX_W-1:0] pos1, k1;

  // Stage 2: partial products
  logic                       v2, cmd2, cis2, last2, thr2;
  logic [fbm_pkg::IDX_W-1:0]  pos2;
  logic [fbm_pkg::PPLL_W-1:0] pn_ll, pc_ll;
  logic [fbm_pkg::PPLH_W-1:0] pn_lh, pc_lh;
  logic [fbm_pkg::PPHL_W-1:0] pn_hl, pc_hl;
  logic [fbm_pkg::PPHH_W-1:0] pn_hh, pc_hh;
  logic [fbm_pkg::RFL_W-1:0]  rf_l;
  logic [fbm_pkg::RFH_W-1:0]  rf_h;
  logic [fbm_pkg::KFL_W-1:0]  kf_l;
  logic [fbm_pkg::KFH_W-1:0]  kf_h;

  // Stage 3: full products
  logic                      v3, cmd3, cis3, last3, thr3;
  logic [fbm_pkg::IDX_W-1:0] pos3;
  logic [fbm_pkg::PN_W-1:0]  pn3, pc3;
  logic [fbm_pkg::RF_W-1:0]  rf3;
  logic [fbm_pkg::KF_W-1:0]  kf3;

  logic                      advance;
  logic                      in_accept;

  // Accept-side counter logic
  logic                      restart;
  logic [fbm_pkg::IDX_W-1:0] pos_eff, k_eff, k_new;
  logic [fbm_pkg::IDX_W-1:0] position_count_next, cis_rank_count_next;
  logic                      in_mark_pass_next;

  // Result-side logic
  logic [fbm_pkg::CUT_W-1:0] rank3;
  logic [fbm_pkg::CUT_W-1:0] trans_fdr_cut_next, cis_fdr_cut_next;
  logic [fbm_pkg::SIG_W-1:0] sig3;
  logic                      emit3;

  assign cfg_ready = !rst;
  assign advance   = !out_valid || out_ready;
  assign in_ready  = advance && !rst;
  assign in_accept = in_valid && in_ready;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      n_total          <= '0;
      n_cis_total      <= '0;
      cis_mode         <= 1'b0;
      bonferroni_alpha <= '0;
      fdr_level        <= '0;
      p_threshold      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (fbm_pkg::cfg_index_t'(cfg_index))
        fbm_pkg::CFG_N_TOTAL:     n_total          <= cfg_data[fbm_pkg::CNT_W-1:0];
        fbm_pkg::CFG_N_CIS_TOTAL: n_cis_total      <= cfg_data[fbm_pkg::CNT_W-1:0];
        fbm_pkg::CFG_CIS_MODE:    cis_mode         <= cfg_data[0];
        fbm_pkg::CFG_BONF_ALPHA:  bonferroni_alpha <= cfg_data;
        fbm_pkg::CFG_FDR_LEVEL:   fdr_level        <= cfg_data;
        fbm_pkg::CFG_P_THRESHOLD: p_threshold      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Work out position and cis rank of the incoming word
  always_comb begin
    restart = (command != in_mark_pass);
    pos_eff = restart ? '0 : position_count;
    k_eff   = restart ? '0 : cis_rank_count;
    k_new   = k_eff + fbm_pkg::IDX_W'(is_cis && (command == fbm_pkg::CMD_SCAN));
    if (last_of_pass) begin
      position_count_next = '0;
      cis_rank_count_next = '0;
      in_mark_pass_next   = !command;
    end else begin
      position_count_next = pos_eff + 1'b1;
      cis_rank_count_next = k_new;
      in_mark_pass_next   = command;
    end
  end

  // Advance pass counters on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      position_count <= '0;
      cis_rank_count <= '0;
      in_mark_pass   <= 1'b0;
    end else if (in_accept) begin
      position_count <= position_count_next;
      cis_rank_count <= cis_rank_count_next;
      in_mark_pass   <= in_mark_pass_next;
    end
  end

  // Pipe valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (advance) begin
      v1 <= in_accept;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Stage 1: capture word with its position
  always_ff @(posedge clk) begin
    if (advance) begin
      cmd1  <= command;
      p1    <= p_value;
      cis1  <= is_cis;
      last1 <= last_of_pass;
      pos1  <= pos_eff;
      k1    <= k_new;
    end
  end

  // Stage 2: partial products of p*N, p*Nc, rank*F and k*F
  always_ff @(posedge clk) begin
    if (advance) begin
      cmd2  <= cmd1;
      cis2  <= cis1;
      last2 <= last1;
      pos2  <= pos1;
      thr2  <= (p1 < p_threshold);
      pn_ll <= fbm_pkg::PPLL_W'(p1[fbm_pkg::PLO_W-1:0])
             * fbm_pkg::PPLL_W'(n_total[fbm_pkg::CLO_W-1:0]);
      pn_lh <= fbm_pkg::PPLH_W'(p1[fbm_pkg::PLO_W-1:0])
             * fbm_pkg::PPLH_W'(n_total[fbm_pkg::CNT_W-1:fbm_pkg::CLO_W]);
      pn_hl <= fbm_pkg::PPHL_W'(p1[fbm_pkg::P_W-1:fbm_pkg::PLO_W])
             * fbm_pkg::PPHL_W'(n_total[fbm_pkg::CLO_W-1:0]);
      pn_hh <= fbm_pkg::PPHH_W'(p1[fbm_pkg::P_W-1:fbm_pkg::PLO_W])
             * fbm_pkg::PPHH_W'(n_total[fbm_pkg::CNT_W-1:fbm_pkg::CLO_W]);
      pc_ll <= fbm_pkg::PPLL_W'(p1[fbm_pkg::PLO_W-1:0])
             * fbm_pkg::PPLL_W'(n_cis_total[fbm_pkg::CLO_W-1:0]);
      pc_lh <= fbm_pkg::PPLH_W'(p1[fbm_pkg::PLO_W-1:0])
             * fbm_pkg::PPLH_W'(n_cis_total[fbm_pkg::CNT_W-1:fbm_pkg::CLO_W]);
      pc_hl <= fbm_pkg::PPHL_W'(p1[fbm_pkg::P_W-1:fbm_pkg::PLO_W])
             * fbm_pkg::PPHL_W'(n_cis_total[fbm_pkg::CLO_W-1:0]);
      pc_hh <= fbm_pkg::PPHH_W'(p1[fbm_pkg::P_W-1:fbm_pkg::PLO_W])
             * fbm_pkg::PPHH_W'(n_cis_total[fbm_pkg::CNT_W-1:fbm_pkg::CLO_W]);
      rf_l  <= fbm_pkg::RFL_W'({1'b0, pos1} + 1'b1)
             * fbm_pkg::RFL_W'(fdr_level[fbm_pkg::PLO_W-1:0]);
      rf_h  <= fbm_pkg::RFH_W'({1'b0, pos1} + 1'b1)
             * fbm_pkg::RFH_W'(fdr_level[fbm_pkg::P_W-1:fbm_pkg::PLO_W]);
      kf_l  <= fbm_pkg::KFL_W'(k1) * fbm_pkg::KFL_W'(fdr_level[fbm_pkg::PLO_W-1:0]);
      kf_h  <= fbm_pkg::KFH_W'(k1)
             * fbm_pkg::KFH_W'(fdr_level[fbm_pkg::P_W-1:fbm_pkg::PLO_W]);
    end
  end

  // Stage 3: sum partial products into full products
  always_ff @(posedge clk) begin
    if (advance) begin
      cmd3  <= cmd2;
      cis3  <= cis2;
      last3 <= last2;
      pos3  <= pos2;
      thr3  <= thr2;
      pn3   <= fbm_pkg::PN_W'(pn_ll)
             + (fbm_pkg::PN_W'(pn_lh) << fbm_pkg::CLO_W)
             + (fbm_pkg::PN_W'(pn_hl) << fbm_pkg::PLO_W)
             + (fbm_pkg::PN_W'(pn_hh) << (fbm_pkg::PLO_W + fbm_pkg::CLO_W));
      pc3   <= fbm_pkg::PN_W'(pc_ll)
             + (fbm_pkg::PN_W'(pc_lh) << fbm_pkg::CLO_W)
             + (fbm_pkg::PN_W'(pc_hl) << fbm_pkg::PLO_W)
             + (fbm_pkg::PN_W'(pc_hh) << (fbm_pkg::PLO_W + fbm_pkg::CLO_W));
      rf3   <= fbm_pkg::RF_W'(rf_l) + (fbm_pkg::RF_W'(rf_h) << fbm_pkg::PLO_W);
      kf3   <= fbm_pkg::KF_W'(kf_l) + (fbm_pkg::KF_W'(kf_h) << fbm_pkg::PLO_W);
    end
  end

  // Compare, update cuts on scan words, build mask on mark words
  always_comb begin
    rank3              = {1'b0, pos3} + 1'b1;
    trans_fdr_cut_next = (pos3 == '0) ? '0 : trans_fdr_cut;
    cis_fdr_cut_next   = (pos3 == '0) ? '0 : cis_fdr_cut;
    if (pn3 <= fbm_pkg::PN_W'(rf3)) begin
      trans_fdr_cut_next = rank3;
    end
    if (cis3 && (pc3 <= fbm_pkg::PN_W'(kf3))) begin
      cis_fdr_cut_next = rank3;
    end

    sig3 = '0;
    if (!cis_mode) begin
      sig3[fbm_pkg::SIG_TRANS_BONF] = (pn3 < fbm_pkg::PN_W'(bonferroni_alpha));
      sig3[fbm_pkg::SIG_TRANS_FDR]  = ({1'b0, pos3} < trans_fdr_cut);
      sig3[fbm_pkg::SIG_THRESHOLD]  = thr3;
    end
    if (cis3) begin
      sig3[fbm_pkg::SIG_CIS_BONF] = (pc3 < fbm_pkg::PN_W'(bonferroni_alpha));
      sig3[fbm_pkg::SIG_CIS_FDR]  = ({1'b0, pos3} < cis_fdr_cut);
    end
    emit3 = v3 && (cmd3 == fbm_pkg::CMD_MARK) && ((sig3 != '0) || last3);
  end

  // Hold the cuts; take new values as scan words leave the pipe
  always_ff @(posedge clk) begin
    if (rst) begin
      trans_fdr_cut <= '0;
      cis_fdr_cut   <= '0;
    end else if (advance && v3 && (cmd3 == fbm_pkg::CMD_SCAN)) begin
      trans_fdr_cut <= trans_fdr_cut_next;
      cis_fdr_cut   <= cis_fdr_cut_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= emit3;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rank_position <= pos3;
      significance  <= sig3;
      last          <= last3;
    end
  end

  // A result word always carries a mark or closes the pass
  a_result_has_content: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((significance != '0) || last))
    else $error("result word with empty mask and no last flag");

  // Scan words never produce a result
  a_scan_no_result: assert property (@(posedge clk) disable iff (rst)
    (advance && v3 && (cmd3 == fbm_pkg::CMD_SCAN)) |=> !out_valid)
    else $error("scan word produced a result");

  // Pass flips and counters clear after the last word of a pass
  a_pass_end: assert property (@(posedge clk) disable iff (rst)
    (in_accept && last_of_pass) |=>
      ((in_mark_pass == !$past(command)) && (position_count == '0)))
    else $error("pass state not updated at end of pass");

endmodule

`default_nettype wire
